FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the placement check block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is low.
`define SPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property, checked in every cycle including reset.
`define SPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/spc_pkg.sv
// Shared types and constants of the spaced connected placement check.
// No dependencies; used by every file of the block except assert_macros.svh.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int MAX_NODES_DEF  = 32;
    localparam int COORD_BITS_DEF = 16;

    localparam int DIST_W     = 15;
    localparam int DSQ_W      = 2 * DIST_W;
    localparam int LIMIT_W    = 6;
    localparam int RETRY_W    = 17;
    localparam int NODE_IDX_W = 5;
    localparam int MASK_W     = 32;
    localparam int OUT_DATA_W = ((NODE_IDX_W + MASK_W + 7) / 8) * 8;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [DIST_W-1:0]  MIN_DIST_RST    = 15'd1600;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST    = 15'd2400;
    localparam logic [LIMIT_W-1:0] NODE_LIMIT_RST  = 6'd32;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 17'd100000;

    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_GIVEUP = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_MIN_DIST    = 2'd0,
        REG_MAX_DIST    = 2'd1,
        REG_NODE_LIMIT  = 2'd2,
        REG_RETRY_LIMIT = 2'd3
    } t_reg_idx;

    // Control flags that travel with the candidate along the cell row.
    typedef struct packed {
        logic valid;
        logic all_far;
        logic sq_valid;
    } t_flags;

endpackage

FILE: rtl/spc_cell.sv
// One cell of the placement row: holds one stored position, squares the distance
// to the passing candidate and finishes the compare of the previous cell's node.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_cell #(
    parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF,
    parameter int MAX_NODES  = spc_pkg::MAX_NODES_DEF,
    parameter int CNT_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [spc_pkg::DSQ_W-1:0]     i_min_sq,
    input  logic [spc_pkg::DSQ_W-1:0]     i_max_sq,
    input  logic                          i_wr_en,
    input  logic signed [COORD_BITS-1:0]  i_wr_x,
    input  logic signed [COORD_BITS-1:0]  i_wr_y,
    input  spc_pkg::t_flags               i_flags,
    input  logic signed [COORD_BITS-1:0]  i_cx,
    input  logic signed [COORD_BITS-1:0]  i_cy,
    input  logic [MAX_NODES-1:0]          i_near,
    input  logic [2*COORD_BITS-1:0]       i_sqx,
    input  logic [2*COORD_BITS-1:0]       i_sqy,
    output spc_pkg::t_flags               o_flags,
    output logic signed [COORD_BITS-1:0]  o_cx,
    output logic signed [COORD_BITS-1:0]  o_cy,
    output logic [MAX_NODES-1:0]          o_near,
    output logic [2*COORD_BITS-1:0]       o_sqx,
    output logic [2*COORD_BITS-1:0]       o_sqy
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int CMP_W = (SQ_W + 1 > spc_pkg::DSQ_W) ? SQ_W + 1 : spc_pkg::DSQ_W;
    localparam int PREV  = (INDEX == 0) ? 0 : INDEX - 1;

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    spc_pkg::t_flags              r_flags;
    logic signed [COORD_BITS-1:0] r_cx;
    logic signed [COORD_BITS-1:0] r_cy;
    logic [MAX_NODES-1:0]         r_near;
    logic [SQ_W-1:0]              r_sqx;
    logic [SQ_W-1:0]              r_sqy;

    spc_pkg::t_flags              n_flags;
    logic [MAX_NODES-1:0]         n_near;
    logic [SQ_W-1:0]              n_sqx;
    logic [SQ_W-1:0]              n_sqy;

    logic [CMP_W-1:0]             sum;
    logic                         far;
    logic                         close;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0]        ax;
    logic [COORD_BITS-1:0]        ay;

    // compare for the node of the previous cell
    assign sum   = CMP_W'(i_sqx) + CMP_W'(i_sqy);
    assign far   = sum > CMP_W'(i_min_sq);
    assign close = sum < CMP_W'(i_max_sq);

    // squared distance to this cell's node
    assign dx = (COORD_BITS + 1)'(i_cx) - (COORD_BITS + 1)'(r_x);
    assign dy = (COORD_BITS + 1)'(i_cy) - (COORD_BITS + 1)'(r_y);
    assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

    always_comb begin
        n_flags.valid    = i_flags.valid;
        n_flags.all_far  = i_flags.all_far & (~i_flags.sq_valid | far);
        n_flags.sq_valid = CNT_W'(INDEX) < i_count;
        n_near           = i_near | (MAX_NODES'(i_flags.sq_valid & close) << PREV);
        n_sqx            = SQ_W'(ax) * SQ_W'(ax);
        n_sqy            = SQ_W'(ay) * SQ_W'(ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx   <= i_cx;
        r_cy   <= i_cy;
        r_near <= n_near;
        r_sqx  <= n_sqx;
        r_sqy  <= n_sqy;
        if (i_wr_en) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
    end

    assign o_flags = r_flags;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_near  = r_near;
    assign o_sqx   = r_sqx;
    assign o_sqy   = r_sqy;

endmodule

FILE: rtl/spaced_connected_placement_check.sv
// A candidate walks the row of MAX_NODES cells, one cell per cycle; the last compare is
// registered in S_RUN, and the verdict in S_DONE once the output register is free.
// A new candidate is taken only in S_IDLE, so one candidate is in flight at a time.
// A finished result may wait in the output register while the next candidate runs.
// Reset clears counters, config registers and control; stored positions are not cleared.
`timescale 1ns / 1ps

module spaced_connected_placement_check #(
    parameter int MAX_NODES  = spc_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cand_x, cand_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // node_index, neighbor_mask
    output logic [spc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [1:0]                        m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spc_pkg::APB_AW-1:0]        paddr,
    input  logic [spc_pkg::APB_DW-1:0]        pwdata,
    output logic [spc_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int LIM_W = (CNT_W > spc_pkg::LIMIT_W) ? CNT_W : spc_pkg::LIMIT_W;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int CMP_W = (SQ_W + 1 > spc_pkg::DSQ_W) ? SQ_W + 1 : spc_pkg::DSQ_W;
    localparam int PAD_W = spc_pkg::OUT_DATA_W - spc_pkg::NODE_IDX_W - spc_pkg::MASK_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                             r_state, n_state;
    logic [spc_pkg::DIST_W-1:0]         r_min_dist, n_min_dist;
    logic [spc_pkg::DIST_W-1:0]         r_max_dist, n_max_dist;
    logic [spc_pkg::LIMIT_W-1:0]        r_node_limit, n_node_limit;
    logic [spc_pkg::RETRY_W-1:0]        r_retry_limit, n_retry_limit;
    logic [spc_pkg::DSQ_W-1:0]          r_min_sq;
    logic [spc_pkg::DSQ_W-1:0]          r_max_sq;
    logic signed [COORD_BITS-1:0]       r_cx, n_cx;
    logic signed [COORD_BITS-1:0]       r_cy, n_cy;
    logic [CNT_W-1:0]                   r_count, n_count;
    logic [spc_pkg::RETRY_W-1:0]        r_retry, n_retry;
    logic                               r_fin_all_far, n_fin_all_far;
    logic [MAX_NODES-1:0]               r_fin_near, n_fin_near;
    logic                               r_out_valid, n_out_valid;
    spc_pkg::t_status                   r_out_status, n_out_status;
    logic [spc_pkg::NODE_IDX_W-1:0]     r_out_idx, n_out_idx;
    logic [spc_pkg::MASK_W-1:0]         r_out_mask, n_out_mask;

    spc_pkg::t_flags                    tap_flags [0:MAX_NODES];
    logic signed [COORD_BITS-1:0]       tap_cx    [0:MAX_NODES];
    logic signed [COORD_BITS-1:0]       tap_cy    [0:MAX_NODES];
    logic [MAX_NODES-1:0]               tap_near  [0:MAX_NODES];
    logic [SQ_W-1:0]                    tap_sqx   [0:MAX_NODES];
    logic [SQ_W-1:0]                    tap_sqy   [0:MAX_NODES];

    logic                               in_xfer;
    logic                               cfg_wr;
    logic [MAX_NODES-1:0]               wr_en;
    logic [CMP_W-1:0]                   fin_sum;
    logic                               fin_far;
    logic                               fin_close;
    logic [LIM_W-1:0]                   limit_eff;
    logic                               store_full;
    logic                               take;
    logic [spc_pkg::RETRY_W:0]          retry_next;
    logic [63:0]                        near_ext;

    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = r_state == S_IDLE;
    assign cfg_wr        = psel & penable & pwrite & pready;
    assign pready        = 1'b1;

    always_comb begin
        unique case (spc_pkg::t_reg_idx'(paddr[3:2]))
            spc_pkg::REG_MIN_DIST:    prdata = spc_pkg::APB_DW'(r_min_dist);
            spc_pkg::REG_MAX_DIST:    prdata = spc_pkg::APB_DW'(r_max_dist);
            spc_pkg::REG_NODE_LIMIT:  prdata = spc_pkg::APB_DW'(r_node_limit);
            spc_pkg::REG_RETRY_LIMIT: prdata = spc_pkg::APB_DW'(r_retry_limit);
        endcase
    end

    // row head
    assign tap_flags[0] = '{valid: in_xfer, all_far: 1'b1, sq_valid: 1'b0};
    assign tap_cx[0]    = s_axis_tdata[COORD_BITS-1:0];
    assign tap_cy[0]    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign tap_near[0]  = '0;
    assign tap_sqx[0]   = '0;
    assign tap_sqy[0]   = '0;

    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        spc_cell #(
            .COORD_BITS (COORD_BITS),
            .MAX_NODES  (MAX_NODES),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_count  (r_count),
            .i_min_sq (r_min_sq),
            .i_max_sq (r_max_sq),
            .i_wr_en  (wr_en[g]),
            .i_wr_x   (r_cx),
            .i_wr_y   (r_cy),
            .i_flags  (tap_flags[g]),
            .i_cx     (tap_cx[g]),
            .i_cy     (tap_cy[g]),
            .i_near   (tap_near[g]),
            .i_sqx    (tap_sqx[g]),
            .i_sqy    (tap_sqy[g]),
            .o_flags  (tap_flags[g+1]),
            .o_cx     (tap_cx[g+1]),
            .o_cy     (tap_cy[g+1]),
            .o_near   (tap_near[g+1]),
            .o_sqx    (tap_sqx[g+1]),
            .o_sqy    (tap_sqy[g+1])
        );
    end

    // compare for the last node of the row
    assign fin_sum   = CMP_W'(tap_sqx[MAX_NODES]) + CMP_W'(tap_sqy[MAX_NODES]);
    assign fin_far   = fin_sum > CMP_W'(r_min_sq);
    assign fin_close = fin_sum < CMP_W'(r_max_sq);

    assign limit_eff  = (LIM_W'(r_node_limit) > LIM_W'(MAX_NODES)) ?
                        LIM_W'(MAX_NODES) : LIM_W'(r_node_limit);
    assign store_full = LIM_W'(r_count) >= limit_eff;
    assign take       = (r_count == '0) || (r_fin_all_far && (r_fin_near != '0));
    assign retry_next = (spc_pkg::RETRY_W + 1)'(r_retry) + 1'b1;
    assign near_ext   = 64'(r_fin_near);

    always_comb begin
        n_state       = r_state;
        n_min_dist    = r_min_dist;
        n_max_dist    = r_max_dist;
        n_node_limit  = r_node_limit;
        n_retry_limit = r_retry_limit;
        n_cx          = r_cx;
        n_cy          = r_cy;
        n_count       = r_count;
        n_retry       = r_retry;
        n_fin_all_far = r_fin_all_far;
        n_fin_near    = r_fin_near;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_idx     = r_out_idx;
        n_out_mask    = r_out_mask;
        wr_en         = '0;

        if (cfg_wr) begin
            unique case (spc_pkg::t_reg_idx'(paddr[3:2]))
                spc_pkg::REG_MIN_DIST:    n_min_dist    = pwdata[spc_pkg::DIST_W-1:0];
                spc_pkg::REG_MAX_DIST:    n_max_dist    = pwdata[spc_pkg::DIST_W-1:0];
                spc_pkg::REG_NODE_LIMIT:  n_node_limit  = pwdata[spc_pkg::LIMIT_W-1:0];
                spc_pkg::REG_RETRY_LIMIT: n_retry_limit = pwdata[spc_pkg::RETRY_W-1:0];
            endcase
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cx    = tap_cx[0];
                    n_cy    = tap_cy[0];
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (tap_flags[MAX_NODES].valid) begin
                    n_fin_all_far = tap_flags[MAX_NODES].all_far &
                                    (~tap_flags[MAX_NODES].sq_valid | fin_far);
                    n_fin_near    = tap_near[MAX_NODES] |
                                    (MAX_NODES'(tap_flags[MAX_NODES].sq_valid & fin_close)
                                     << (MAX_NODES - 1));
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = '0;
                    n_out_mask  = '0;
                    n_state     = S_IDLE;
                    priority if (store_full) begin
                        n_out_status = spc_pkg::ST_FULL;
                    end else if (take) begin
                        wr_en[r_count[IDX_W-1:0]] = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_retry      = '0;
                        n_out_status = spc_pkg::ST_ACCEPT;
                        n_out_idx    = spc_pkg::NODE_IDX_W'(r_count);
                        n_out_mask   = near_ext[spc_pkg::MASK_W-1:0];
                    end else if (retry_next > (spc_pkg::RETRY_W + 1)'(r_retry_limit)) begin
                        n_count      = CNT_W'(1);
                        n_retry      = '0;
                        n_out_status = spc_pkg::ST_GIVEUP;
                    end else begin
                        n_retry      = retry_next[spc_pkg::RETRY_W-1:0];
                        n_out_status = spc_pkg::ST_REJECT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_min_dist    <= spc_pkg::MIN_DIST_RST;
            r_max_dist    <= spc_pkg::MAX_DIST_RST;
            r_node_limit  <= spc_pkg::NODE_LIMIT_RST;
            r_retry_limit <= spc_pkg::RETRY_LIMIT_RST;
            r_count       <= '0;
            r_retry       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_min_dist    <= n_min_dist;
            r_max_dist    <= n_max_dist;
            r_node_limit  <= n_node_limit;
            r_retry_limit <= n_retry_limit;
            r_count       <= n_count;
            r_retry       <= n_retry;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_sq      <= spc_pkg::DSQ_W'(r_min_dist) * spc_pkg::DSQ_W'(r_min_dist);
        r_max_sq      <= spc_pkg::DSQ_W'(r_max_dist) * spc_pkg::DSQ_W'(r_max_dist);
        r_cx          <= n_cx;
        r_cy          <= n_cy;
        r_fin_all_far <= n_fin_all_far;
        r_fin_near    <= n_fin_near;
        r_out_status  <= n_out_status;
        r_out_idx     <= n_out_idx;
        r_out_mask    <= n_out_mask;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {PAD_W'(0), r_out_mask, r_out_idx};
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: rtl/spc_chk.sv
// Port-level checker for the spaced connected placement check, bound to the top level.
// Depends on spc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spc_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [spc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]                     m_axis_tuser
);

    // one candidate in flight at a time
    `SPC_ASSERT(a_one_in_flight, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken twice in a row")

    // only an accepted node carries an index and a mask
    `SPC_ASSERT(a_zero_payload, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser != spc_pkg::ST_ACCEPT)) |-> (m_axis_tdata == '0), "payload set on non-accept result")

    // the first node of a run has no neighbors
    `SPC_ASSERT(a_first_alone, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser == spc_pkg::ST_ACCEPT) && (m_axis_tdata[4:0] == 5'd0)) |-> (m_axis_tdata[36:5] == 32'd0), "node zero with neighbors")

    // stalled result holds
    `SPC_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "result changed under stall")

endmodule

bind spaced_connected_placement_check spc_chk u_spc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/testbench.sv
// Self-checking bench for spaced_connected_placement_check: candidate stream in, verdict stream out.
// Uses spc_pkg and the block's RTL; the expected verdicts come from a placement predictor kept here.
`timescale 1ns / 1ps

module testbench;
    import spc_pkg::*;

    localparam int NODES    = MAX_NODES_DEF;
    localparam int LATENCY  = NODES + 1;
    localparam int WATCHDOG = 3000;

    typedef struct packed {
        t_status                 status;
        logic [NODE_IDX_W-1:0]   node;
        logic [MASK_W-1:0]       links;
    } t_placement;

    // value holds {y, x} for a candidate, or the register value for a write
    typedef struct packed {
        logic                    is_cfg;
        t_reg_idx                reg_sel;
        logic [31:0]             value;
        logic                    typed;
        t_status                 status;
        logic [NODE_IDX_W-1:0]   node;
        logic [MASK_W-1:0]       links;
    } t_row;

    typedef struct packed {
        logic [DIST_W-1:0]       min_d;
        logic [DIST_W-1:0]       max_d;
        logic [LIMIT_W-1:0]      nodes;
        logic [RETRY_W-1:0]      retries;
        logic [11:0]             items;
        logic                    gaps;
    } t_phase;

    localparam int DIR_ROWS = 33;
    localparam t_row DIR_TABLE [DIR_ROWS] = '{
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_ACCEPT, 5'd0, 32'h0}, // empty store
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_REJECT, 5'd0, 32'h0}, // on top of node 0
        '{1'b0, REG_MIN_DIST,    32'h0000_07D0, 1'b1, ST_ACCEPT, 5'd1, 32'h1},
        '{1'b0, REG_MIN_DIST,    32'h0000_0640, 1'b1, ST_REJECT, 5'd0, 32'h0}, // exactly min
        '{1'b0, REG_MIN_DIST,    32'h0960_0000, 1'b1, ST_REJECT, 5'd0, 32'h0}, // exactly max
        '{1'b0, REG_MIN_DIST,    32'h095F_0000, 1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h8000_8000, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h7FFF_7FFF, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h7FFF_8000, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h8000_7FFF, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b1, REG_RETRY_LIMIT, 32'd0,         1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_GIVEUP, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_GIVEUP, 5'd0, 32'h0},
        '{1'b1, REG_RETRY_LIMIT, 32'd2,         1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b1, REG_NODE_LIMIT,  32'd2,         1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_07D0, 1'b1, ST_ACCEPT, 5'd1, 32'h1},
        '{1'b0, REG_MIN_DIST,    32'h0064_0064, 1'b1, ST_FULL,   5'd0, 32'h0},
        '{1'b1, REG_NODE_LIMIT,  32'd0,         1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0005_0005, 1'b1, ST_FULL,   5'd0, 32'h0},
        '{1'b1, REG_NODE_LIMIT,  32'd63,        1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_GIVEUP, 5'd0, 32'h0},
        '{1'b1, REG_MIN_DIST,    32'd2400,      1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b1, REG_MAX_DIST,    32'd1600,      1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_07D0, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b1, REG_MIN_DIST,    32'd0,         1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b1, REG_MAX_DIST,    32'd32767,     1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_0001, 1'b1, ST_ACCEPT, 5'd1, 32'h1},
        '{1'b0, REG_MIN_DIST,    32'h8000_8000, 1'b1, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_7FFF, 1'b0, ST_REJECT, 5'd0, 32'h0},
        '{1'b0, REG_MIN_DIST,    32'h0000_0000, 1'b1, ST_REJECT, 5'd0, 32'h0}
    };

    localparam int PHASE_CNT = 8;
    localparam t_phase PHASES [PHASE_CNT] = '{
        '{15'd1600,  15'd2400,  6'd30, 17'd6,      12'd350, 1'b1},
        '{15'd16,    15'd40,    6'd20, 17'd2,      12'd300, 1'b1},
        '{15'd0,     15'd1000,  6'd30, 17'd1,      12'd250, 1'b1},
        '{15'd1600,  15'd2400,  6'd1,  17'd1,      12'd30,  1'b1},
        '{15'd32767, 15'd0,     6'd24, 17'd131071, 12'd80,  1'b1},
        '{15'd100,   15'd32767, 6'd24, 17'd12,     12'd300, 1'b1},
        '{15'd800,   15'd1200,  6'd8,  17'd4,      12'd300, 1'b0},
        '{15'd1600,  15'd2400,  6'd63, 17'd131071, 12'd350, 1'b0}
    };

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [31:0]                       s_axis_tdata = '0;   // cand_x, cand_y
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0]             m_axis_tdata;        // node_index, neighbor_mask
    logic [1:0]                        m_axis_tuser;        // status
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [APB_AW-1:0]                 paddr = '0;
    logic [APB_DW-1:0]                 pwdata = '0;
    logic [APB_DW-1:0]                 prdata;
    logic                              pready;

    // predictor state and its view of the registers
    logic [DIST_W-1:0]                 spacing    = MIN_DIST_RST;
    logic [DIST_W-1:0]                 link_range = MAX_DIST_RST;
    logic [LIMIT_W-1:0]                node_cap   = NODE_LIMIT_RST;
    logic [RETRY_W-1:0]                retry_cap  = RETRY_LIMIT_RST;
    logic signed [15:0]                site_x [NODES];
    logic signed [15:0]                site_y [NODES];
    int                                sites_placed = 0;
    int                                rejections = 0;

    t_placement                        pending_results [$];
    int                                mismatches = 0;
    int                                quiet_cycles = 0;
    int                                stall_left = 0;
    bit                                gaps_on = 1'b0;

    spaced_connected_placement_check uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_placement place_candidate(logic signed [15:0] cx,
                                                   logic signed [15:0] cy);
        t_placement res;
        longint dx, dy, d2, min_sq, max_sq;
        logic [MASK_W-1:0] near;
        bit all_far;
        int cap;
        res = '{ST_REJECT, '0, '0};
        cap = (int'(node_cap) > NODES) ? NODES : int'(node_cap);
        if (sites_placed >= cap) begin
            res.status = ST_FULL;
            return res;
        end
        min_sq = longint'(spacing) * longint'(spacing);
        max_sq = longint'(link_range) * longint'(link_range);
        near = '0;
        all_far = 1'b1;
        for (int i = 0; i < sites_placed; i++) begin
            dx = longint'(cx) - longint'(site_x[i]);
            dy = longint'(cy) - longint'(site_y[i]);
            d2 = dx * dx + dy * dy;
            if (d2 <= min_sq)
                all_far = 1'b0;
            if (d2 < max_sq)
                near[i] = 1'b1;
        end
        if (sites_placed == 0 || (all_far && near != 0)) begin
            site_x[sites_placed] = cx;
            site_y[sites_placed] = cy;
            res = '{ST_ACCEPT, 5'(sites_placed), near};
            sites_placed++;
            rejections = 0;
        end else begin
            rejections++;
            if (rejections > int'(retry_cap)) begin
                sites_placed = 1;
                rejections = 0;
                res.status = ST_GIVEUP;
            end
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp_coord(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // Well-formed: a ring point between min and max around a placed node, or a jitter if no ring fits.
    // Noise: fully random, or a small jitter around a placed node. An empty store gives a fully random point.
    function automatic void pick_candidate(input bit noisy,
                                           output logic signed [15:0] cx,
                                           output logic signed [15:0] cy);
        int j, r, ox, oy, lo, hi;
        lo = int'(spacing) + 1;
        hi = int'(link_range) - 1;
        if (sites_placed == 0 || (noisy && $urandom_range(0, 1) == 0)) begin
            cx = 16'($urandom);
            cy = 16'($urandom);
            return;
        end
        j = $urandom_range(0, sites_placed - 1);
        if (noisy || lo > hi) begin
            ox = int'($urandom_range(0, 63)) - 32;
            oy = int'($urandom_range(0, 63)) - 32;
        end else begin
            r = $urandom_range(lo, hi);
            ox = $urandom_range(0, r);
            oy = $rtoi($sqrt(real'(r) * real'(r) - real'(ox) * real'(ox)));
            if ($urandom_range(0, 1) == 1)
                ox = -ox;
            if ($urandom_range(0, 1) == 1)
                oy = -oy;
        end
        cx = clamp_coord(int'(site_x[j]) + ox);
        cy = clamp_coord(int'(site_y[j]) + oy);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_candidate(logic signed [15:0] cx, logic signed [15:0] cy, bit typed,
                                  t_status st, logic [NODE_IDX_W-1:0] nd,
                                  logic [MASK_W-1:0] lk);
        t_placement got;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tdata  = {cy, cx};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        got = place_candidate(cx, cy);
        if (typed)
            got = '{st, nd, lk};
        pending_results = {pending_results, got};
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx sel, logic [31:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (sel)
            REG_MIN_DIST:    spacing    = v[DIST_W-1:0];
            REG_MAX_DIST:    link_range = v[DIST_W-1:0];
            REG_NODE_LIMIT:  node_cap   = v[LIMIT_W-1:0];
            REG_RETRY_LIMIT: retry_cap  = v[RETRY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!gaps_on) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("transfer with nothing pending", m_axis_tuser, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[NODE_IDX_W-1:0] !== want.node)
                    report_mismatch("node_index", m_axis_tdata[NODE_IDX_W-1:0], want.node);
                if (m_axis_tdata[NODE_IDX_W +: MASK_W] !== want.links)
                    report_mismatch("neighbor_mask", m_axis_tdata[NODE_IDX_W +: MASK_W],
                                    want.links);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic signed [15:0] cx, cy;
        int noise_left;
        t_phase ph;
        noise_left = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (DIR_TABLE[k].is_cfg) begin
                wait_drained();
                write_reg(DIR_TABLE[k].reg_sel, DIR_TABLE[k].value);
            end else begin
                send_candidate(DIR_TABLE[k].value[15:0], DIR_TABLE[k].value[31:16],
                               DIR_TABLE[k].typed, DIR_TABLE[k].status,
                               DIR_TABLE[k].node, DIR_TABLE[k].links);
            end
        end

        for (int p = 0; p < PHASE_CNT; p++) begin
            ph = PHASES[p];
            // force a give-up so each phase grows a fresh layout from node 0
            wait_drained();
            write_reg(REG_NODE_LIMIT, 32'd31);
            write_reg(REG_RETRY_LIMIT, 32'd0);
            send_candidate(site_x[0], site_y[0], 1'b0, ST_REJECT, '0, '0);
            wait_drained();
            write_reg(REG_MIN_DIST, 32'(ph.min_d));
            write_reg(REG_MAX_DIST, 32'(ph.max_d));
            write_reg(REG_NODE_LIMIT, 32'(ph.nodes));
            write_reg(REG_RETRY_LIMIT, 32'(ph.retries));
            gaps_on = ph.gaps;
            noise_left = 0;
            repeat (ph.items) begin
                if (noise_left == 0 && $urandom_range(0, 24) == 0)
                    noise_left = $urandom_range(1, 12);
                if (noise_left != 0) begin
                    noise_left--;
                    pick_candidate(1'b1, cx, cy);
                end else begin
                    pick_candidate($urandom_range(0, 9) == 0, cx, cy);
                end
                send_candidate(cx, cy, 1'b0, ST_REJECT, '0, '0);
            end
        end

        gaps_on = 1'b0;
        wait_drained();
        repeat (LATENCY + 4) @(negedge i_clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
